FILE: rtl/core/message_deframer_zero_mask_unit_assert.svh
// Assertion macros for the zero-mask message deframer.
`ifndef MESSAGE_DEFRAMER_ZERO_MASK_UNIT_ASSERT_SVH
`define MESSAGE_DEFRAMER_ZERO_MASK_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MDZM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MDZM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mdzm_pkg.sv
// Package: sizes, role and status codes of the zero-mask message deframer.
`timescale 1ns / 1ps
package mdzm_pkg;

    localparam int MAX_MESSAGE_BYTES  = 256;
    // position saturates at MAX_MESSAGE_BYTES
    localparam int POS_W              = $clog2(MAX_MESSAGE_BYTES + 1);
    // next length position reaches at most MAX - 1 + 255 + 1
    localparam int NLP_W              = $clog2(MAX_MESSAGE_BYTES + 256 + 1);
    localparam int FIRST_ARG_POSITION = 6;

    typedef enum logic [2:0] {
        ROLE_TYPE    = 3'd0,
        ROLE_TAG     = 3'd1,
        ROLE_TARGET  = 3'd2,
        ROLE_COMMAND = 3'd3,
        ROLE_SENDER  = 3'd4,
        ROLE_LENGTH  = 3'd5,
        ROLE_DATA    = 3'd6,
        ROLE_END     = 3'd7
    } t_role;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_CHECKSUM = 2'd2
    } t_status;

endpackage

FILE: rtl/core/message_deframer_zero_mask_unit.sv
// Top level: streaming deframer for zero-masked messages.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (i_in_valid / o_in_ready): one received byte per item, with
//   i_is_last flagging the checksum byte that closes a message. The first
//   byte of every message is the zero mask; it gives no result.
//   Output channel (o_out_valid / i_out_ready): one result per header or
//   argument byte (decoded data, role, argument index) and one closing
//   status result per message (role end, status, argument count,
//   end_of_message set). Bytes past the length limit give no result.
//   Flow: an accepted item lands in the input register, and its result
//   moves into the output register once the result slot is free; that
//   register drives o_out_valid. Throughput: one item per cycle while
//   i_out_ready stays high. The rate is set by the single decode step
//   between the input register and the output register: mask compare,
//   8-bit checksum add and one position / length-position update per cycle.
//   Stall: while a result waits in the output register and the receiver
//   holds i_out_ready low, the input register still takes one more item;
//   then o_in_ready drops until the result is taken.
//   Reset (i_rst_n low, synchronous): both registers empty, the message
//   state returns to awaiting the mask byte, the stored mask clears to zero.
//
module message_deframer_zero_mask_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_raw_byte,
    input  logic       i_is_last,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data,
    output logic [2:0] o_role,
    output logic [7:0] o_arg_index,
    output logic [1:0] o_status,
    output logic [7:0] o_arg_count,
    output logic       o_end_of_message
);

    localparam int PW = mdzm_pkg::POS_W;
    localparam int NW = mdzm_pkg::NLP_W;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // message state
    logic [7:0]    r_zero_mask,  n_zero_mask;
    logic [PW-1:0] r_position,   n_position;
    logic [NW-1:0] r_next_len,   n_next_len;
    logic [7:0]    r_sum,        n_sum;
    logic [7:0]    r_arg_total,  n_arg_total;
    logic          r_too_long,   n_too_long;

    // result register
    logic       r_out_valid;
    logic [7:0] r_data,      n_data;
    logic [2:0] r_role,      n_role;
    logic [7:0] r_arg_index, n_arg_index;
    logic [1:0] r_status,    n_status;
    logic [7:0] r_arg_count, n_arg_count;
    logic       r_eom,       n_eom;
    logic       n_emit;

    logic       advance;
    logic [7:0] dec;

    // Move the held item through decode whenever the result slot is free
    // or being emptied this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign dec = (r_in_byte == r_zero_mask) ? 8'd0 : r_in_byte;

    always_comb begin
        n_zero_mask = r_zero_mask;
        n_position  = r_position;
        n_next_len  = r_next_len;
        n_sum       = r_sum;
        n_arg_total = r_arg_total;
        n_too_long  = r_too_long;
        n_emit      = 1'b0;
        n_data      = 8'd0;
        n_role      = mdzm_pkg::ROLE_END;
        n_arg_index = 8'd0;
        n_status    = mdzm_pkg::ST_OK;
        n_arg_count = 8'd0;
        n_eom       = 1'b0;

        if (r_position == '0) begin
            // mask byte: store it; a lone mask byte closes as badly formed
            n_zero_mask = r_in_byte;
            if (r_in_last) begin
                n_emit   = 1'b1;
                n_status = mdzm_pkg::ST_BAD;
                n_eom    = 1'b1;
            end else begin
                n_position = PW'(1);
            end
        end else if (r_in_last) begin
            // checksum byte: close the message and clear its state
            n_emit      = 1'b1;
            n_eom       = 1'b1;
            n_arg_count = r_arg_total;
            if (r_position < PW'(mdzm_pkg::FIRST_ARG_POSITION) || r_too_long ||
                r_position >= PW'(mdzm_pkg::MAX_MESSAGE_BYTES)) begin
                n_status = mdzm_pkg::ST_BAD;
            end else if (r_sum != dec) begin
                n_status = mdzm_pkg::ST_CHECKSUM;
            end else begin
                n_status = mdzm_pkg::ST_OK;
            end
            n_position  = '0;
            n_next_len  = NW'(mdzm_pkg::FIRST_ARG_POSITION);
            n_sum       = 8'd0;
            n_arg_total = 8'd0;
            n_too_long  = 1'b0;
        end else if (r_position >= PW'(mdzm_pkg::MAX_MESSAGE_BYTES)) begin
            // over length: drop the byte, remember the overrun
            n_too_long = 1'b1;
            n_position = PW'(mdzm_pkg::MAX_MESSAGE_BYTES);
        end else begin
            n_emit     = 1'b1;
            n_data     = dec;
            n_sum      = r_sum + dec;
            n_position = r_position + PW'(1);
            if (r_position < PW'(mdzm_pkg::FIRST_ARG_POSITION)) begin
                // header byte: role follows position
                n_role = 3'(r_position - PW'(1));
            end else if (NW'(r_position) == r_next_len) begin
                n_role      = mdzm_pkg::ROLE_LENGTH;
                n_arg_index = r_arg_total;
                if (r_arg_total != 8'd255) begin
                    n_arg_total = r_arg_total + 8'd1;
                end
                n_next_len = NW'(r_position) + NW'(dec) + NW'(1);
            end else begin
                n_role      = mdzm_pkg::ROLE_DATA;
                n_arg_index = (r_arg_total != 8'd0) ? r_arg_total - 8'd1 : 8'd0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_zero_mask <= 8'd0;
            r_position  <= '0;
            r_next_len  <= NW'(mdzm_pkg::FIRST_ARG_POSITION);
            r_sum       <= 8'd0;
            r_arg_total <= 8'd0;
            r_too_long  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= n_emit;
                r_zero_mask <= n_zero_mask;
                r_position  <= n_position;
                r_next_len  <= n_next_len;
                r_sum       <= n_sum;
                r_arg_total <= n_arg_total;
                r_too_long  <= n_too_long;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_raw_byte;
            r_in_last <= i_is_last;
        end
        if (advance && n_emit) begin
            r_data      <= n_data;
            r_role      <= n_role;
            r_arg_index <= n_arg_index;
            r_status    <= n_status;
            r_arg_count <= n_arg_count;
            r_eom       <= n_eom;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data           = r_data;
    assign o_role           = r_role;
    assign o_arg_index      = r_arg_index;
    assign o_status         = r_status;
    assign o_arg_count      = r_arg_count;
    assign o_end_of_message = r_eom;

`include "message_deframer_zero_mask_unit_assert.svh"

    // the closing result always carries the end role
    `MDZM_ASSERT_IMP(a_eom_role, o_out_valid && o_end_of_message, o_role == mdzm_pkg::ROLE_END, "end result without end role")

    // byte results carry no status and no count
    `MDZM_ASSERT_IMP(a_byte_clean, o_out_valid && !o_end_of_message, o_status == mdzm_pkg::ST_OK && o_arg_count == 8'd0, "status or count on a byte result")

    // a decoded last byte returns the deframer to awaiting the mask
    `MDZM_ASSERT_NXT(a_last_clears, advance && r_in_last, r_position == '0 && r_sum == 8'd0 && !r_too_long, "message state not cleared after last byte")

    // position never runs past the length limit
    `MDZM_ASSERT_IMP(a_pos_limit, 1'b1, r_position <= PW'(mdzm_pkg::MAX_MESSAGE_BYTES), "position beyond limit")

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the zero-mask message deframer.
`timescale 1ns / 1ps

module testbench;
    import mdzm_pkg::*;

    // One decoded result, field for field as the block presents it.
    typedef struct packed {
        logic [7:0] data;
        t_role      role;
        logic [7:0] arg_index;
        t_status    status;
        logic [7:0] arg_count;
        logic       eom;
    } deframe_result_t;

    // How a directed row is checked: no result at all, a result typed into
    // the table, or whatever the predictor works out.
    typedef enum logic [1:0] {
        CHECK_NONE    = 2'd0,
        CHECK_TYPED   = 2'd1,
        CHECK_PREDICT = 2'd2
    } check_kind_e;

    typedef enum logic [1:0] {
        SHAPE_GOOD    = 2'd0,
        SHAPE_BAD_SUM = 2'd1,
        SHAPE_NOISE   = 2'd2
    } frame_shape_e;

    typedef struct packed {
        logic [7:0]      raw;
        logic            last;
        check_kind_e     kind;
        deframe_result_t want;
    } stim_row_t;

    localparam deframe_result_t NO_RESULT = '0;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 80;

    // Directed messages, in order:
    //   a lone mask byte flagged last, right after reset (one-byte message);
    //   a short message, mask plus four header bytes plus checksum;
    //   a well-formed message with mask 0xFF, two arguments (one empty),
    //   header and data bytes equal to the mask decoding to zero;
    //   a header-only message whose checksum byte equals the mask, so it is
    //   taken as zero and mismatches the running sum.
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{8'hA5, 1'b1, CHECK_TYPED, '{8'd0, ROLE_END, 8'd0, ST_BAD, 8'd0, 1'b1}},
        '{8'h00, 1'b0, CHECK_NONE, NO_RESULT},
        '{8'h80, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h7F, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h01, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'hFE, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h55, 1'b1, CHECK_TYPED, '{8'd0, ROLE_END, 8'd0, ST_BAD, 8'd0, 1'b1}},
        '{8'hFF, 1'b0, CHECK_NONE, NO_RESULT},
        '{8'hFF, 1'b0, CHECK_TYPED, '{8'd0, ROLE_TYPE, 8'd0, ST_OK, 8'd0, 1'b0}},
        '{8'h00, 1'b0, CHECK_TYPED, '{8'd0, ROLE_TAG, 8'd0, ST_OK, 8'd0, 1'b0}},
        '{8'h7E, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h81, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h01, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h02, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'hFF, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h80, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h00, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h82, 1'b1, CHECK_TYPED, '{8'd0, ROLE_END, 8'd0, ST_OK, 8'd2, 1'b1}},
        '{8'h33, 1'b0, CHECK_NONE, NO_RESULT},
        '{8'h33, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h01, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h02, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h03, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h04, 1'b0, CHECK_PREDICT, NO_RESULT},
        '{8'h33, 1'b1, CHECK_TYPED, '{8'd0, ROLE_END, 8'd0, ST_CHECKSUM, 8'd0, 1'b1}}
    };

    // Body size of the long message sent in the last phase: bytes past the
    // limit are dropped and the checksum lands beyond it.
    localparam int LONG_BODY = 257;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_raw_byte = 8'd0;
    logic       i_is_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_data;
    logic [2:0] o_role;
    logic [7:0] o_arg_index;
    logic [1:0] o_status;
    logic [7:0] o_arg_count;
    logic       o_end_of_message;

    // Predictor copy of the message state.
    logic [7:0] msg_mask = 8'd0;
    int         msg_pos = 0;
    int         msg_next_len = FIRST_ARG_POSITION;
    logic [7:0] msg_sum = 8'd0;
    logic [7:0] msg_args = 8'd0;
    bit         msg_too_long = 1'b0;

    deframe_result_t pending_results[$];
    logic [8:0]      link_bytes[$];   // {is_last, raw byte} of the next message
    int              tx_idle_pct = 33;
    int              rx_idle_pct = 86;
    int              fault_count = 0;
    int              stall_cycles = 0;

    message_deframer_zero_mask_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_raw_byte       (i_raw_byte),
        .i_is_last        (i_is_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_data           (o_data),
        .o_role           (o_role),
        .o_arg_index      (o_arg_index),
        .o_status         (o_status),
        .o_arg_count      (o_arg_count),
        .o_end_of_message (o_end_of_message)
    );

    always #2 i_clk = ~i_clk;

    // Return the message state to awaiting the mask byte; the mask stays.
    function automatic void restart_message();
        msg_pos      = 0;
        msg_next_len = FIRST_ARG_POSITION;
        msg_sum      = 8'd0;
        msg_args     = 8'd0;
        msg_too_long = 1'b0;
    endfunction

    // Advance the predictor by one received byte; return 1 when it yields a result.
    function automatic bit deframe_byte(input logic [7:0] raw, input logic last,
                                        output deframe_result_t res);
        logic [7:0] dec;
        res = '{8'd0, ROLE_END, 8'd0, ST_OK, 8'd0, 1'b0};
        if (msg_pos == 0) begin
            msg_mask = raw;
            if (!last) begin
                msg_pos = 1;
                return 1'b0;
            end
            res.status = ST_BAD;
            res.eom    = 1'b1;
            restart_message();
            return 1'b1;
        end
        dec = (raw == msg_mask) ? 8'd0 : raw;
        if (last) begin
            // badly formed wins over a checksum mismatch
            if (msg_pos < FIRST_ARG_POSITION || msg_too_long || msg_pos >= MAX_MESSAGE_BYTES)
                res.status = ST_BAD;
            else if (msg_sum != dec)
                res.status = ST_CHECKSUM;
            res.arg_count = msg_args;
            res.eom       = 1'b1;
            restart_message();
            return 1'b1;
        end
        if (msg_pos >= MAX_MESSAGE_BYTES) begin
            // past the limit: swallow the byte, remember the overrun
            msg_too_long = 1'b1;
            msg_pos      = MAX_MESSAGE_BYTES;
            return 1'b0;
        end
        msg_sum  = msg_sum + dec;
        res.data = dec;
        if (msg_pos < FIRST_ARG_POSITION) begin
            res.role = t_role'(msg_pos - 1);
        end else if (msg_pos == msg_next_len) begin
            res.role      = ROLE_LENGTH;
            res.arg_index = msg_args;
            if (msg_args < 8'd255)
                msg_args = msg_args + 8'd1;
            msg_next_len = msg_pos + int'(dec) + 1;
        end else begin
            res.role      = ROLE_DATA;
            res.arg_index = (msg_args > 0) ? msg_args - 8'd1 : 8'd0;
        end
        msg_pos++;
        return 1'b1;
    endfunction

    // Encode a decoded value; zero goes out as the mask half of the time.
    function automatic logic [7:0] mask_encode(input logic [7:0] value, input logic [7:0] mask);
        if (value == 8'd0 && $urandom_range(1) == 1)
            return mask;
        return value;
    endfunction

    // Offer one item, hold it until accepted, then log what it should produce.
    task automatic send_item(input logic [7:0] raw, input logic last,
                             input check_kind_e kind, input deframe_result_t want);
        deframe_result_t predicted;
        bit              produced;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_byte <= raw;
        i_is_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // accepted at this edge
        produced = deframe_byte(raw, last, predicted);
        if (kind == CHECK_TYPED)
            pending_results.push_back(want);
        else if (kind == CHECK_PREDICT && produced)
            pending_results.push_back(predicted);
    endtask

    // Build one message into link_bytes. n_body counts the bytes between the
    // mask and the checksum.
    task automatic queue_frame(input frame_shape_e shape, input int n_body);
        logic [7:0] mask;
        logic [7:0] raw;
        logic [7:0] dec;
        logic [7:0] sum;
        int         len;
        int         data_left;
        link_bytes.delete();
        case ($urandom_range(9))
            0: mask = 8'h00;
            1: mask = 8'hFF;
            default: mask = 8'($urandom);
        endcase
        link_bytes.push_back({1'b0, mask});
        if (shape == SHAPE_NOISE) begin
            repeat (n_body) link_bytes.push_back({1'b0, 8'($urandom)});
            link_bytes.push_back({1'b1, 8'($urandom)});
            return;
        end
        sum       = 8'd0;
        data_left = 0;
        for (int k = 0; k < n_body; k++) begin
            if (k >= 5 && data_left == 0) begin
                // argument length byte, trimmed so the argument fits the body
                len = ($urandom_range(4) == 0) ? $urandom_range(30) : $urandom_range(6);
                if (len > n_body - k - 1)
                    len = n_body - k - 1;
                if (len == int'(mask) && len != 0)
                    len = 0;
                dec       = 8'(len);
                raw       = mask_encode(dec, mask);
                data_left = len;
            end else begin
                raw = ($urandom_range(6) == 0) ? mask : 8'($urandom);
                dec = (raw == mask) ? 8'd0 : raw;
                if (k >= 5)
                    data_left--;
            end
            sum = sum + dec;
            link_bytes.push_back({1'b0, raw});
        end
        if (shape == SHAPE_BAD_SUM)
            raw = sum + 8'($urandom_range(255, 1));
        else if (sum == mask && sum != 8'd0)
            raw = sum;   // not encodable; closes with a checksum error
        else
            raw = mask_encode(sum, mask);
        link_bytes.push_back({1'b1, raw});
    endtask

    task automatic send_frame();
        logic [8:0] b;
        while (link_bytes.size() != 0) begin
            b = link_bytes.pop_front();
            send_item(b[7:0], b[8], CHECK_PREDICT, NO_RESULT);
        end
    endtask

    // Receiver: drop ready at random at the current phase's rate.
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        deframe_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: data %0d role %0d status %0d",
                       o_data, o_role, o_status);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_data !== want.data) begin
                    $error("data: expected %0d actual %0d", want.data, o_data);
                    fault_count++;
                end
                if (o_role !== want.role) begin
                    $error("role: expected %0d actual %0d", want.role, o_role);
                    fault_count++;
                end
                if (o_arg_index !== want.arg_index) begin
                    $error("arg_index: expected %0d actual %0d", want.arg_index, o_arg_index);
                    fault_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_status);
                    fault_count++;
                end
                if (o_arg_count !== want.arg_count) begin
                    $error("arg_count: expected %0d actual %0d", want.arg_count, o_arg_count);
                    fault_count++;
                end
                if (o_end_of_message !== want.eom) begin
                    $error("end_of_message: expected %0d actual %0d", want.eom,
                           o_end_of_message);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("message_deframer_zero_mask_unit regression: fail");
            $finish;
        end
    end

    initial begin
        int           phase_items;
        int           pick;
        int           n_body;
        frame_shape_e shape;

        // hold reset, then release
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, under the first idling phase.
        foreach (DIRECTED_ROWS[r])
            send_item(DIRECTED_ROWS[r].raw, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].want);

        // Random messages in three idling phases: sender light / receiver heavy,
        // the reverse, then no idling at all. The last phase opens with the
        // long message.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 86 : 0;
            rx_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 33 : 0;
            phase_items = 0;
            if (phase == 2) begin
                queue_frame(SHAPE_GOOD, LONG_BODY);
                send_frame();
            end
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 68)
                    shape = SHAPE_GOOD;
                else if (pick < 82)
                    shape = SHAPE_BAD_SUM;
                else
                    shape = SHAPE_NOISE;
                if (shape == SHAPE_NOISE)
                    n_body = $urandom_range(10);
                else if ($urandom_range(3) != 0)
                    n_body = 5 + $urandom_range(15);
                else
                    n_body = 21 + $urandom_range(40);
                queue_frame(shape, n_body);
                phase_items += link_bytes.size();
                send_frame();
            end
        end
        i_in_valid <= 1'b0;

        // drain the expected results, then let the pipeline settle
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("message_deframer_zero_mask_unit regression: pass");
        else
            $display("message_deframer_zero_mask_unit regression: fail");
        $finish;
    end

endmodule
